### rtl/core/hpr_pkg.sv
// ============================================================================
// hpr_pkg : shared types and constants for the hazard pointer reclaimer
// Sizes, payload structs, controller states and the controller/datapath
// command and status structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

    // Sizing
    localparam int THREADS      = 8;
    localparam int SLOTS        = 4;
    localparam int RETIRE_DEPTH = 32;
    localparam int PTR_BITS     = 48;

    localparam int HAZ_ENTRIES  = THREADS * SLOTS * 2;
    localparam int HAZ_AW       = (HAZ_ENTRIES > 1) ? $clog2(HAZ_ENTRIES) : 1;
    localparam int IDX_W        = $clog2(RETIRE_DEPTH);
    localparam int CNT_W        = $clog2(RETIRE_DEPTH + 1);
    localparam int THR_W        = 6;

    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(20);

    // Command codes
    localparam logic [1:0] CMD_PUBLISH = 2'd0;
    localparam logic [1:0] CMD_RETIRE  = 2'd1;
    localparam logic [1:0] CMD_FLUSH   = 2'd2;

    // Status codes
    localparam logic ST_FREED    = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [2:0]          thread_id;
        logic [1:0]          slot_index;
        logic                slot_kind;
        logic [PTR_BITS-1:0] pointer_value;
    } t_in_item;

    typedef struct packed {
        logic [PTR_BITS-1:0] freed_pointer;
        logic                last;
        logic                status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FL_RD,
        S_FL_EMIT,
        S_SC_RD,
        S_SC_HZ,
        S_SC_DEC,
        S_SC_FIN,
        S_CP_RD,
        S_CP_WR,
        S_CP_END
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_TOP,
        IDX_DEC,
        IDX_INC,
        IDX_CLR
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_CLR,
        CNT_WPTR
    } t_cnt_op;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_REJECT,
        OUT_FLUSH,
        OUT_PEND,
        OUT_PEND_LAST
    } t_out_op;

    // Controller to datapath
    typedef struct packed {
        logic    latch;
        logic    haz_wr;
        logic    list_wr;
        logic    list_rd;
        logic    scan_clr;
        logic    scan_init;
        logic    haz_rd;
        logic    decide;
        logic    cp_wr;
        logic    wptr_clr;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_out_op out_op;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       pub_ok;
        logic       list_full;
        logic       list_empty;
        logic       scan_need;
        logic       idx_zero;
        logic       idx_top;
        logic       hidx_last;
        logic       hit;
        logic       pend_vld;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/hazard_pointer_reclaimer_unit.sv
// ============================================================================
// hazard_pointer_reclaimer_unit : hazard pointer reclamation engine
// Hazard table, retire list and scan/flush sequencer in one command block.
// ============================================================================
// A command is taken when start is high and busy is low; busy stays high until
// the command is done. A rejected retire gives its one result through the result
// register, set in the decode state. A scan walks the list one pointer at a time
// and sweeps the whole hazard table through its single read port for each,
// then packs the survivors. A flush emits the listed pointers one at a time,
// newest first. Results come on o_result with o_strobe for exactly one cycle
// each and cannot be held off; o_result.last marks the final one of a command.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module hazard_pointer_reclaimer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  hpr_pkg::t_in_item            i_item,
    input  wire                          i_cfg_we,
    input  wire [hpr_pkg::THR_W-1:0]     i_cfg_wdata,
    output logic                         o_strobe,
    output hpr_pkg::t_out_item           o_result
);

    hpr_pkg::t_dp_cmd  w_cmd;
    hpr_pkg::t_dp_stat w_stat;

    // Sequencer
    hpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Storage and match logic
    hpr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

### rtl/core/hpr_ctrl.sv
// ============================================================================
// hpr_ctrl : reclaimer sequencer
// Steps publish, retire, scan, compaction and flush through the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hpr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  hpr_pkg::t_dp_stat   i_stat,
    output hpr_pkg::t_dp_cmd    o_cmd
);

    hpr_pkg::t_state r_state;
    hpr_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != hpr_pkg::S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.idx_op     = hpr_pkg::IDX_HOLD;
        o_cmd.cnt_op     = hpr_pkg::CNT_HOLD;
        o_cmd.out_op     = hpr_pkg::OUT_NONE;

        unique case (r_state)
            hpr_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = hpr_pkg::S_DECODE;
                end
            end

            hpr_pkg::S_DECODE: begin
                n_state = hpr_pkg::S_IDLE;
                if (i_stat.cmd == hpr_pkg::CMD_PUBLISH) begin
                    o_cmd.haz_wr = i_stat.pub_ok;
                end else if (i_stat.cmd == hpr_pkg::CMD_RETIRE) begin
                    if (i_stat.list_full) begin
                        o_cmd.out_op = hpr_pkg::OUT_REJECT;
                    end else begin
                        o_cmd.list_wr  = 1'b1;
                        o_cmd.cnt_op   = hpr_pkg::CNT_INC;
                        o_cmd.idx_op   = hpr_pkg::IDX_CNT;
                        o_cmd.scan_clr = 1'b1;
                        if (i_stat.scan_need) begin
                            n_state = hpr_pkg::S_SC_RD;
                        end
                    end
                end else if (i_stat.cmd == hpr_pkg::CMD_FLUSH) begin
                    if (!i_stat.list_empty) begin
                        o_cmd.idx_op = hpr_pkg::IDX_TOP;
                        n_state      = hpr_pkg::S_FL_RD;
                    end
                end
            end

            // Flush: newest to oldest, one entry at a time, read then emit
            hpr_pkg::S_FL_RD: begin
                o_cmd.list_rd = 1'b1;
                n_state       = hpr_pkg::S_FL_EMIT;
            end

            hpr_pkg::S_FL_EMIT: begin
                o_cmd.out_op = hpr_pkg::OUT_FLUSH;
                if (i_stat.idx_zero) begin
                    o_cmd.cnt_op = hpr_pkg::CNT_CLR;
                    n_state      = hpr_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_op = hpr_pkg::IDX_DEC;
                    n_state      = hpr_pkg::S_FL_RD;
                end
            end

            // Scan: fetch one listed pointer, sweep the hazard table
            hpr_pkg::S_SC_RD: begin
                o_cmd.list_rd   = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state         = hpr_pkg::S_SC_HZ;
            end

            hpr_pkg::S_SC_HZ: begin
                o_cmd.haz_rd = 1'b1;
                if (i_stat.hidx_last) begin
                    n_state = hpr_pkg::S_SC_DEC;
                end
            end

            hpr_pkg::S_SC_DEC: begin
                o_cmd.decide = 1'b1;
                // a new free pushes the held one out; it is not the last
                if (!i_stat.hit && i_stat.pend_vld) begin
                    o_cmd.out_op = hpr_pkg::OUT_PEND;
                end
                if (i_stat.idx_zero) begin
                    n_state = hpr_pkg::S_SC_FIN;
                end else begin
                    o_cmd.idx_op = hpr_pkg::IDX_DEC;
                    n_state      = hpr_pkg::S_SC_RD;
                end
            end

            hpr_pkg::S_SC_FIN: begin
                if (i_stat.pend_vld) begin
                    o_cmd.out_op = hpr_pkg::OUT_PEND_LAST;
                end
                o_cmd.idx_op   = hpr_pkg::IDX_CLR;
                o_cmd.wptr_clr = 1'b1;
                n_state        = hpr_pkg::S_CP_RD;
            end

            // Compaction: oldest to newest, survivors packed downward
            hpr_pkg::S_CP_RD: begin
                o_cmd.list_rd = 1'b1;
                n_state       = hpr_pkg::S_CP_WR;
            end

            hpr_pkg::S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_stat.idx_top) begin
                    n_state = hpr_pkg::S_CP_END;
                end else begin
                    o_cmd.idx_op = hpr_pkg::IDX_INC;
                    n_state      = hpr_pkg::S_CP_RD;
                end
            end

            hpr_pkg::S_CP_END: begin
                o_cmd.cnt_op = hpr_pkg::CNT_WPTR;
                n_state      = hpr_pkg::S_IDLE;
            end

            default: begin
                n_state = hpr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/hpr_datapath.sv
// ============================================================================
// hpr_datapath : hazard table, retire list and result register
// Holds both memories, the list counters, the match logic and the
// one-deep held result used to mark the last free of a scan.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hpr_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  hpr_pkg::t_in_item            i_item,
    input  wire                          i_cfg_we,
    input  wire [hpr_pkg::THR_W-1:0]     i_cfg_wdata,
    input  hpr_pkg::t_dp_cmd             i_cmd,
    output hpr_pkg::t_dp_stat            o_stat,
    output logic                         o_strobe,
    output hpr_pkg::t_out_item           o_result
);

    localparam int DEPTH = hpr_pkg::RETIRE_DEPTH;
    localparam int HAZN  = hpr_pkg::HAZ_ENTRIES;
    localparam int IW    = hpr_pkg::IDX_W;
    localparam int CW    = hpr_pkg::CNT_W;
    localparam int HW    = hpr_pkg::HAZ_AW;
    localparam int PW    = hpr_pkg::PTR_BITS;

    // Latched command
    hpr_pkg::t_in_item r_item;

    // Memories
    logic [PW-1:0]   r_haz [HAZN];
    logic [HAZN-1:0] r_haz_vld;
    logic [PW-1:0]   r_list [DEPTH];

    logic [PW-1:0]   r_haz_rd;
    logic            r_haz_rd_vld;
    logic [PW-1:0]   r_list_rd;

    // Counters and scan state
    logic [hpr_pkg::THR_W-1:0] r_thresh;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_wptr;
    logic [IW-1:0]   r_idx;
    logic [HW-1:0]   r_hidx;
    logic            r_cmp_en;
    logic            r_hit;
    logic [DEPTH-1:0] r_keep;
    logic [PW-1:0]   r_pend;
    logic            r_pend_vld;

    logic            r_out_vld;
    hpr_pkg::t_out_item r_out;

    logic [HW-1:0]   w_haz_addr;
    logic [CW-1:0]   w_thr_eff;
    logic            w_match;
    logic            w_hit;
    logic [IW-1:0]   w_list_wa;
    logic            w_list_we;

    // Publish address; the range check is in the status block
    assign w_haz_addr = HW'((32'(r_item.thread_id) * hpr_pkg::SLOTS
                             + 32'(r_item.slot_index)) * 2 + 32'(r_item.slot_kind));

    // Effective threshold saturates at depth minus one
    always_comb begin
        if (32'(r_thresh) > DEPTH - 1) begin
            w_thr_eff = CW'(DEPTH - 1);
        end else begin
            w_thr_eff = CW'(r_thresh);
        end
    end

    // Hazard match against the pointer under test; null never protects
    assign w_match = r_haz_rd_vld && (r_haz_rd != '0) && (r_haz_rd == r_list_rd);
    assign w_hit   = r_hit | (r_cmp_en & w_match);

    // Status to controller
    always_comb begin
        o_stat.cmd        = r_item.cmd;
        o_stat.pub_ok     = (32'(r_item.thread_id) < hpr_pkg::THREADS)
                         && (32'(r_item.slot_index) < hpr_pkg::SLOTS);
        o_stat.list_full  = (32'(r_count) >= DEPTH);
        o_stat.list_empty = (r_count == '0);
        o_stat.scan_need  = ({1'b0, r_count} + 1'b1) > {1'b0, w_thr_eff};
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_top    = (r_idx == IW'(r_count - 1'b1));
        o_stat.hidx_last  = (r_hidx == HW'(HAZN - 1));
        o_stat.hit        = w_hit;
        o_stat.pend_vld   = r_pend_vld;
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= hpr_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Hazard table, valid bits stand for the null reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.haz_wr) begin
            r_haz[w_haz_addr] <= r_item.pointer_value;
        end
        if (i_cmd.haz_rd) begin
            r_haz_rd <= r_haz[r_hidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_haz_vld    <= '0;
            r_haz_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.haz_wr) begin
                r_haz_vld[w_haz_addr] <= 1'b1;
            end
            if (i_cmd.haz_rd) begin
                r_haz_rd_vld <= r_haz_vld[r_hidx];
            end
        end
    end

    // Retire list, single write and single read port
    assign w_list_we = i_cmd.list_wr | (i_cmd.cp_wr & r_keep[r_idx]);
    assign w_list_wa = i_cmd.list_wr ? r_count[IW-1:0] : r_wptr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            r_list[w_list_wa] <= i_cmd.list_wr ? r_item.pointer_value : r_list_rd;
        end
        if (i_cmd.list_rd) begin
            r_list_rd <= r_list[r_idx];
        end
    end

    // Count, index and compaction write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.cnt_op)
                hpr_pkg::CNT_INC:  r_count <= r_count + 1'b1;
                hpr_pkg::CNT_CLR:  r_count <= '0;
                hpr_pkg::CNT_WPTR: r_count <= r_wptr;
                default:           r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.idx_op)
            hpr_pkg::IDX_CNT: r_idx <= r_count[IW-1:0];
            hpr_pkg::IDX_TOP: r_idx <= IW'(r_count - 1'b1);
            hpr_pkg::IDX_DEC: r_idx <= r_idx - 1'b1;
            hpr_pkg::IDX_INC: r_idx <= r_idx + 1'b1;
            hpr_pkg::IDX_CLR: r_idx <= '0;
            default:          r_idx <= r_idx;
        endcase
        if (i_cmd.wptr_clr) begin
            r_wptr <= '0;
        end else if (i_cmd.cp_wr && r_keep[r_idx]) begin
            r_wptr <= r_wptr + 1'b1;
        end
    end

    // Hazard sweep per listed pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.haz_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_hidx <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_cmd.haz_rd) begin
                r_hidx <= r_hidx + 1'b1;
            end
            if (r_cmp_en && w_match) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Survivor flags and the held free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_keep     <= '0;
        end else if (i_cmd.scan_clr) begin
            r_pend_vld <= 1'b0;
            r_keep     <= '0;
        end else if (i_cmd.decide) begin
            if (w_hit) begin
                r_keep[r_idx] <= 1'b1;
            end else begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && !w_hit) begin
            r_pend <= r_list_rd;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= (i_cmd.out_op != hpr_pkg::OUT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_op)
            hpr_pkg::OUT_REJECT: begin
                r_out.freed_pointer <= r_item.pointer_value;
                r_out.last          <= 1'b1;
                r_out.status        <= hpr_pkg::ST_REJECTED;
            end
            hpr_pkg::OUT_FLUSH: begin
                r_out.freed_pointer <= r_list_rd;
                r_out.last          <= (r_idx == '0);
                r_out.status        <= hpr_pkg::ST_FREED;
            end
            hpr_pkg::OUT_PEND: begin
                r_out.freed_pointer <= r_pend;
                r_out.last          <= 1'b0;
                r_out.status        <= hpr_pkg::ST_FREED;
            end
            hpr_pkg::OUT_PEND_LAST: begin
                r_out.freed_pointer <= r_pend;
                r_out.last          <= 1'b1;
                r_out.status        <= hpr_pkg::ST_FREED;
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

### dv/testbench.sv
// ============================================================================
// testbench : self-checking bench for hazard_pointer_reclaimer_unit
// Drives publish, retire, flush and unused commands through the start/busy
// handshake. A predictor tracks the hazard table, retire list and scan
// threshold, and queues the pointers each command should free or reject.
// Every strobed result is compared field by field with the oldest entry.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD = 20;
    localparam int IDLE_LIMIT = 20000;   // longer than a full-list scan
    localparam int PHASE_ITEMS = 14;
    localparam int POOL_SIZE = 6;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // DUT signals
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    hpr_pkg::t_in_item           i_item;
    logic                        i_cfg_we;
    logic [hpr_pkg::THR_W-1:0]   i_cfg_wdata;
    logic                        o_strobe;
    hpr_pkg::t_out_item          o_result;

    // Predictor state
    logic [hpr_pkg::PTR_BITS-1:0] hazard_shadow [hpr_pkg::HAZ_ENTRIES];
    logic [hpr_pkg::PTR_BITS-1:0] retire_shadow [hpr_pkg::RETIRE_DEPTH];
    int                           retire_fill;
    int                           scan_thr;
    hpr_pkg::t_out_item           pending_frees [$];
    hpr_pkg::t_out_item           exp_r;

    // Stimulus helpers
    logic [hpr_pkg::PTR_BITS-1:0] ptr_pool [POOL_SIZE];
    int                           burst_left;
    int                           errors;
    int                           idle_cycles;

    // Run statistics
    int n_publish, n_retire, n_flush, n_unused;
    int n_results, n_scans, n_rejects, n_thr_writes;

    hazard_pointer_reclaimer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_guarded(logic [hpr_pkg::PTR_BITS-1:0] p);
        for (int i = 0; i < hpr_pkg::HAZ_ENTRIES; i++) begin
            if (hazard_shadow[i] != '0 && hazard_shadow[i] == p)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_reclaim(input hpr_pkg::t_in_item it);
        hpr_pkg::t_out_item           r;
        hpr_pkg::t_out_item           freed [$];
        logic [hpr_pkg::PTR_BITS-1:0] keep [$];
        int                           eff_thr;
        int                           idx;
        r.last = 1'b0;
        case (it.cmd)
            hpr_pkg::CMD_PUBLISH: begin
                n_publish++;
                if (it.thread_id < hpr_pkg::THREADS && it.slot_index < hpr_pkg::SLOTS) begin
                    idx = (int'(it.thread_id) * hpr_pkg::SLOTS + int'(it.slot_index)) * 2
                          + int'(it.slot_kind);
                    hazard_shadow[idx] = it.pointer_value;
                end
            end
            hpr_pkg::CMD_RETIRE: begin
                n_retire++;
                if (retire_fill >= hpr_pkg::RETIRE_DEPTH) begin
                    // list full: pointer comes straight back
                    n_rejects++;
                    r.freed_pointer = it.pointer_value;
                    r.status = hpr_pkg::ST_REJECTED;
                    freed.push_back(r);
                end else begin
                    retire_shadow[retire_fill] = it.pointer_value;
                    retire_fill++;
                    eff_thr = (scan_thr > hpr_pkg::RETIRE_DEPTH - 1)
                              ? hpr_pkg::RETIRE_DEPTH - 1 : scan_thr;
                    if (retire_fill > eff_thr) begin
                        // scan newest to oldest, survivors keep their order
                        n_scans++;
                        for (int k = retire_fill - 1; k >= 0; k--) begin
                            if (is_guarded(retire_shadow[k])) begin
                                keep.push_front(retire_shadow[k]);
                            end else begin
                                r.freed_pointer = retire_shadow[k];
                                r.status = hpr_pkg::ST_FREED;
                                freed.push_back(r);
                            end
                        end
                        foreach (keep[k]) retire_shadow[k] = keep[k];
                        retire_fill = keep.size();
                    end
                end
            end
            hpr_pkg::CMD_FLUSH: begin
                n_flush++;
                for (int k = retire_fill - 1; k >= 0; k--) begin
                    r.freed_pointer = retire_shadow[k];
                    r.status = hpr_pkg::ST_FREED;
                    freed.push_back(r);
                end
                retire_fill = 0;
            end
            default: begin
                n_unused++;
            end
        endcase
        if (freed.size() > 0) begin
            r = freed[freed.size() - 1];
            r.last = 1'b1;
            freed[freed.size() - 1] = r;
        end
        foreach (freed[k]) pending_frees.push_back(freed[k]);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (pending_frees.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual ptr=%h last=%b st=%b",
                         $time, o_result.freed_pointer, o_result.last, o_result.status);
            end else begin
                exp_r = pending_frees.pop_front();
                if (o_result.freed_pointer !== exp_r.freed_pointer) begin
                    errors++;
                    $display("%0t: freed_pointer mismatch: expected %h actual %h",
                             $time, exp_r.freed_pointer, o_result.freed_pointer);
                end
                if (o_result.last !== exp_r.last) begin
                    errors++;
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, exp_r.last, o_result.last);
                end
                if (o_result.status !== exp_r.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %b actual %b",
                             $time, exp_r.status, o_result.status);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_frees.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic pause(input int n);
        if (n > 0) begin
            start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // One command transfer; start stays high on return
    task automatic send_item(input hpr_pkg::t_in_item it);
        i_item = it;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_reclaim(it);
        @(negedge i_clk);
    endtask

    // Bursts of random length with random gaps, some long gap-free stretches
    task automatic send_paced(input hpr_pkg::t_in_item it);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = 20;
            end else begin
                pause($urandom_range(1, 8));
                burst_left = $urandom_range(1, 6);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    // Block idle: nothing outstanding and no command in progress
    task automatic wait_idle();
        start = 1'b0;
        while (pending_frees.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_threshold(input int v);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v[hpr_pkg::THR_W-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        scan_thr    = v & ((1 << hpr_pkg::THR_W) - 1);
        n_thr_writes++;
    endtask

    function automatic hpr_pkg::t_in_item make_item(logic [1:0] c, int tid, int slot,
                                                    int kind,
                                                    logic [hpr_pkg::PTR_BITS-1:0] p);
        hpr_pkg::t_in_item it;
        it.cmd           = c;
        it.thread_id     = tid[2:0];
        it.slot_index    = slot[1:0];
        it.slot_kind     = kind[0];
        it.pointer_value = p;
        return it;
    endfunction

    function automatic logic [hpr_pkg::PTR_BITS-1:0] rand_ptr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[hpr_pkg::PTR_BITS-1:0];
    endfunction

    // Mostly pooled values so hazards hit, some null, some fully random
    function automatic logic [hpr_pkg::PTR_BITS-1:0] pick_pointer();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll <= 6)
            return ptr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return rand_ptr();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Publish, scan with protected/null/duplicate entries, flush, ignored cmds
    task automatic test_publish_retire_scan();
        logic [hpr_pkg::PTR_BITS-1:0] pa, pb, ones;
        pa   = rand_ptr() | 48'h1;
        pb   = pa ^ 48'h8000_0000_0000;
        ones = '1;
        write_threshold(2);
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 0, 0, 0, pa));
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 7, 3, 1, ones));
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, pa));
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, '0));     // null retire
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  7, 3, 1, pb));     // frees pb and null
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, ones));
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, pa));     // duplicate, none
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 0, 0, 0, '0));     // clear hazard on pa
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, pb));     // frees pb, both pa
        send_paced(make_item(hpr_pkg::CMD_FLUSH,   0, 0, 0, '0));     // protected ones goes
        send_paced(make_item(hpr_pkg::CMD_FLUSH,   5, 1, 1, ones));   // empty list
        send_paced(make_item(CMD_UNUSED,           3, 2, 1, pa));     // ignored
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 7, 3, 1, '0));
    endtask

    // Threshold zero: every retire scans
    task automatic test_threshold_zero();
        logic [hpr_pkg::PTR_BITS-1:0] pc;
        pc = rand_ptr();
        write_threshold(0);
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  2, 2, 0, pc));
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 3, 1, 0, pc));
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  1, 0, 1, pc));
        send_paced(make_item(hpr_pkg::CMD_FLUSH,   0, 0, 0, '0));
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 3, 1, 0, '0));
    endtask

    // Fill the list with protected pointers until a retire is rejected
    task automatic test_full_list();
        logic [hpr_pkg::PTR_BITS-1:0] pp;
        pp = ptr_pool[0];
        write_threshold(63);                 // saturates to depth minus one
        send_paced(make_item(hpr_pkg::CMD_FLUSH,   0, 0, 0, '0));
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 5, 2, 1, pp));
        repeat (hpr_pkg::RETIRE_DEPTH)
            send_paced(make_item(hpr_pkg::CMD_RETIRE, 0, 0, 0, pp));
        send_paced(make_item(hpr_pkg::CMD_RETIRE,  0, 0, 0, rand_ptr()));   // rejected
        send_paced(make_item(hpr_pkg::CMD_FLUSH,   0, 0, 0, '0));
        send_paced(make_item(hpr_pkg::CMD_PUBLISH, 5, 2, 1, '0));
    endtask

    // Random mix under one threshold setting
    task automatic test_random_traffic(input int thr, input int count);
        int                sent;
        int                roll;
        hpr_pkg::t_in_item it;
        write_threshold(thr);
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            it.thread_id     = 3'($urandom_range(0, hpr_pkg::THREADS - 1));
            it.slot_index    = 2'($urandom_range(0, hpr_pkg::SLOTS - 1));
            it.slot_kind     = 1'($urandom_range(0, 1));
            it.pointer_value = pick_pointer();
            if (roll < 35)
                it.cmd = hpr_pkg::CMD_PUBLISH;
            else if (roll < 87)
                it.cmd = hpr_pkg::CMD_RETIRE;
            else if (roll < 96)
                it.cmd = hpr_pkg::CMD_FLUSH;
            else
                it.cmd = CMD_UNUSED;
            send_paced(it);
            if (it.cmd != CMD_UNUSED) sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        errors      = 0;
        burst_left  = 0;
        retire_fill = 0;
        scan_thr    = int'(hpr_pkg::THRESH_RESET);
        n_publish = 0; n_retire = 0; n_flush = 0; n_unused = 0;
        n_results = 0; n_scans = 0; n_rejects = 0; n_thr_writes = 0;
        foreach (hazard_shadow[i]) hazard_shadow[i] = '0;
        foreach (retire_shadow[i]) retire_shadow[i] = '0;
        ptr_pool[0] = rand_ptr() | 48'h1;
        ptr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) ptr_pool[i] = rand_ptr();

        // Synchronous reset, released on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_publish_retire_scan();
        test_threshold_zero();
        test_full_list();
        test_random_traffic(1, PHASE_ITEMS);
        test_random_traffic(63, PHASE_ITEMS);
        test_random_traffic(0, PHASE_ITEMS);
        test_random_traffic($urandom_range(2, 62), PHASE_ITEMS);
        test_random_traffic(int'(hpr_pkg::THRESH_RESET), PHASE_ITEMS / 2);

        // Drain and let the block settle
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d publish, %0d retire, %0d flush, %0d unused commands",
                 n_publish, n_retire, n_flush, n_unused);
        $display("%0d results checked, %0d scans, %0d rejected retires, %0d threshold writes",
                 n_results, n_scans, n_rejects, n_thr_writes);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
